// ===== rtl/core/binary_min_heap_queue_unit_assert.svh =====
// Assertion macros for the binary min-heap queue unit.
`ifndef BINARY_MIN_HEAP_QUEUE_UNIT_ASSERT_SVH
`define BINARY_MIN_HEAP_QUEUE_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Property must hold at every clock edge outside reset.
`define BMHQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Expression must never be true at a clock edge outside reset.
`define BMHQ_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`else

`define BMHQ_ASSERT(lbl, prop, msg)

`define BMHQ_ASSERT_NEVER(lbl, expr, msg)

`endif

`endif

// ===== rtl/core/bmhq_pkg.sv =====
// Types and default constants shared by the binary min-heap queue unit.
`default_nettype none

package bmhq_pkg;

  localparam int unsigned CAPACITY_DEF = 64;
  localparam int unsigned KEY_BITS_DEF = 32;
  localparam int unsigned ID_BITS_DEF  = 16;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_PEEK   = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_UNDERFLOW = 2'd1,
    STAT_OVERFLOW  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SWIM_RD,
    ST_SWIM_CMP,
    ST_DEL_LOAD,
    ST_SINK_RD,
    ST_SINK_CMP,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

// ===== rtl/core/binary_min_heap_queue_unit.sv =====
// Binary min-heap priority queue of key/id entries held in a synchronous memory.
//
// Channel   Dir  tdata (low bit up)                     tuser
// s_axis    in   in_key, in_id                          cmd
// m_axis    out  out_key, out_id, count, empty_res      status
//
// Peek and any command that fails on an empty or full heap go straight to the done state.
// Insert: the new entry climbs a level per parent read and compare until it stops or reaches the root.
// Delete: the last entry refills the root and sinks level by level; emptying the heap skips both.
// Reset empties the heap at once; the memory itself is never cleared.
// A new beat is taken only when the previous one is finished, while its result
// may still wait in the output register; a held result stalls the block in its last cycle.
`default_nettype none

`include "binary_min_heap_queue_unit_assert.svh"

module binary_min_heap_queue_unit
  import bmhq_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF,
  parameter int unsigned KEY_BITS = KEY_BITS_DEF,
  parameter int unsigned ID_BITS  = ID_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid_i,
  output logic s_axis_tready_o,
  // in_key, in_id
  input  logic [((KEY_BITS+ID_BITS+7)/8)*8-1:0] s_axis_tdata_i,
  // cmd
  input  logic [1:0] s_axis_tuser_i,
  output logic m_axis_tvalid_o,
  input  logic m_axis_tready_i,
  // out_key, out_id, count, empty_res
  output logic [((KEY_BITS+ID_BITS+$clog2(CAPACITY+1)+1+7)/8)*8-1:0] m_axis_tdata_o,
  // status
  output logic [1:0] m_axis_tuser_o
);

  localparam int unsigned AW     = $clog2(CAPACITY);
  localparam int unsigned CW     = $clog2(CAPACITY + 1);
  localparam int unsigned EW     = KEY_BITS + ID_BITS;
  localparam int unsigned OUT_FW = KEY_BITS + ID_BITS + CW + 1;
  localparam int unsigned OUT_DW = ((OUT_FW + 7) / 8) * 8;

  // Entries are stored with the key in the low bits.
  logic [EW-1:0] heap_mem [CAPACITY];
  logic [EW-1:0] rdata_a_q, rdata_b_q;

  state_e state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] pos_q, pos_d;
  logic [KEY_BITS-1:0] cur_key_q, cur_key_d;
  logic [ID_BITS-1:0] cur_id_q, cur_id_d;
  logic [KEY_BITS-1:0] root_key_q;
  logic [ID_BITS-1:0] root_id_q;
  status_e res_status_q, res_status_d;
  logic res_use_root_q, res_use_root_d;
  logic [KEY_BITS-1:0] res_key_q, res_key_d;
  logic [ID_BITS-1:0] res_id_q, res_id_d;
  logic out_valid_q;
  logic [OUT_DW-1:0] out_data_q;
  status_e out_status_q;

  logic mem_we;
  logic [AW-1:0] mem_waddr;
  logic [EW-1:0] mem_wdata;
  logic [AW-1:0] rd_addr_a, rd_addr_b;

  logic s_fire;
  cmd_e cmd;
  logic heap_full, heap_empty;
  logic [CW:0] child_pos;
  logic has_child, has_right;
  logic [KEY_BITS-1:0] left_key, right_key, parent_key;
  logic pick_right;
  logic [EW-1:0] pick_entry;
  logic [KEY_BITS-1:0] pick_key;
  logic swap_up, swap_down;
  logic out_free;
  logic [KEY_BITS-1:0] fin_key;
  logic [ID_BITS-1:0] fin_id;
  logic op_busy;
  logic ins_grow;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;
  assign cmd             = cmd_e'(s_axis_tuser_i);
  assign heap_full       = (count_q == CW'(CAPACITY));
  assign heap_empty      = (count_q == '0);

  // Children of the current hole, 1-based.
  assign child_pos  = {pos_q, 1'b0};
  assign has_child  = (child_pos <= {1'b0, count_q});
  assign has_right  = (child_pos < {1'b0, count_q});

  assign left_key   = rdata_a_q[KEY_BITS-1:0];
  assign right_key  = rdata_b_q[KEY_BITS-1:0];
  assign parent_key = rdata_a_q[KEY_BITS-1:0];
  assign pick_right = has_right && (left_key > right_key);
  assign pick_entry = pick_right ? rdata_b_q : rdata_a_q;
  assign pick_key   = pick_entry[KEY_BITS-1:0];
  // Strict compares: equal keys never move.
  assign swap_up    = (parent_key > cur_key_q);
  assign swap_down  = (cur_key_q > pick_key);

  assign out_free   = !out_valid_q || m_axis_tready_i;

  assign op_busy  = (state_q inside {ST_SWIM_RD, ST_SWIM_CMP, ST_SINK_RD, ST_SINK_CMP});
  assign ins_grow = s_fire && (cmd == CMD_INSERT) && !heap_full;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          case (cmd)
            CMD_INSERT: state_d = heap_full ? ST_DONE : ST_SWIM_RD;
            CMD_DELETE: state_d = heap_empty ? ST_DONE : ST_DEL_LOAD;
            default:    state_d = ST_DONE;
          endcase
        end
      end
      ST_SWIM_RD:  state_d = (pos_q == CW'(1)) ? ST_DONE : ST_SWIM_CMP;
      ST_SWIM_CMP: state_d = swap_up ? ST_SWIM_RD : ST_DONE;
      ST_DEL_LOAD: state_d = heap_empty ? ST_DONE : ST_SINK_RD;
      ST_SINK_RD:  state_d = has_child ? ST_SINK_CMP : ST_DONE;
      ST_SINK_CMP: state_d = swap_down ? ST_SINK_RD : ST_DONE;
      ST_DONE:     state_d = out_free ? ST_IDLE : ST_DONE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    count_d        = count_q;
    pos_d          = pos_q;
    cur_key_d      = cur_key_q;
    cur_id_d       = cur_id_q;
    res_status_d   = res_status_q;
    res_use_root_d = res_use_root_q;
    res_key_d      = res_key_q;
    res_id_d       = res_id_q;
    mem_we         = 1'b0;
    mem_waddr      = AW'(pos_q - 1'b1);
    mem_wdata      = {cur_id_q, cur_key_q};
    rd_addr_a      = '0;
    rd_addr_b      = '0;
    case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          res_key_d = '0;
          res_id_d  = '0;
          case (cmd)
            CMD_INSERT: begin
              res_use_root_d = 1'b1;
              if (heap_full) begin
                res_status_d = STAT_OVERFLOW;
              end else begin
                res_status_d = STAT_OK;
                count_d      = count_q + 1'b1;
                pos_d        = count_q + 1'b1;
                cur_key_d    = s_axis_tdata_i[KEY_BITS-1:0];
                cur_id_d     = s_axis_tdata_i[KEY_BITS +: ID_BITS];
              end
            end
            CMD_DELETE: begin
              res_use_root_d = 1'b0;
              if (heap_empty) begin
                res_status_d = STAT_UNDERFLOW;
              end else begin
                res_status_d = STAT_OK;
                res_key_d    = root_key_q;
                res_id_d     = root_id_q;
                count_d      = count_q - 1'b1;
                // Fetch the last entry; it refills the root.
                rd_addr_a    = AW'(count_q - 1'b1);
              end
            end
            default: begin
              res_use_root_d = !heap_empty;
              res_status_d   = heap_empty ? STAT_UNDERFLOW : STAT_OK;
            end
          endcase
        end
      end
      ST_SWIM_RD: begin
        if (pos_q == CW'(1)) begin
          mem_we = 1'b1;
        end else begin
          rd_addr_a = AW'((pos_q >> 1) - 1'b1);
        end
      end
      ST_SWIM_CMP: begin
        mem_we = 1'b1;
        if (swap_up) begin
          mem_wdata = rdata_a_q;
          pos_d     = pos_q >> 1;
        end
      end
      ST_DEL_LOAD: begin
        cur_key_d = rdata_a_q[KEY_BITS-1:0];
        cur_id_d  = rdata_a_q[KEY_BITS +: ID_BITS];
        pos_d     = CW'(1);
      end
      ST_SINK_RD: begin
        if (has_child) begin
          rd_addr_a = AW'(child_pos - 1'b1);
          rd_addr_b = has_right ? AW'(child_pos) : AW'(child_pos - 1'b1);
        end else begin
          mem_we = 1'b1;
        end
      end
      ST_SINK_CMP: begin
        mem_we = 1'b1;
        if (swap_down) begin
          mem_wdata = pick_entry;
          pos_d     = pick_right ? CW'(child_pos + 1'b1) : CW'(child_pos);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      heap_mem[mem_waddr] <= mem_wdata;
    end
    rdata_a_q <= heap_mem[rd_addr_a];
    rdata_b_q <= heap_mem[rd_addr_b];
  end

  // The root is mirrored in flops so that peek and insert results need no read.
  always_ff @(posedge clk_i) begin
    if (mem_we && (mem_waddr == '0)) begin
      root_key_q <= mem_wdata[KEY_BITS-1:0];
      root_id_q  <= mem_wdata[KEY_BITS +: ID_BITS];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if ((state_q == ST_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign fin_key = res_use_root_q ? root_key_q : res_key_q;
  assign fin_id  = res_use_root_q ? root_id_q : res_id_q;

  always_ff @(posedge clk_i) begin
    pos_q          <= pos_d;
    cur_key_q      <= cur_key_d;
    cur_id_q       <= cur_id_d;
    res_status_q   <= res_status_d;
    res_use_root_q <= res_use_root_d;
    res_key_q      <= res_key_d;
    res_id_q       <= res_id_d;
    if ((state_q == ST_DONE) && out_free) begin
      out_status_q <= res_status_q;
      out_data_q   <= OUT_DW'({heap_empty, count_q, fin_id, fin_key});
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_status_q;

  `BMHQ_ASSERT(a_count_bound, count_q <= CW'(CAPACITY), "entry count above capacity")
  `BMHQ_ASSERT_NEVER(a_no_write_idle, mem_we && !op_busy, "heap write outside an operation")
  `BMHQ_ASSERT(a_insert_grows, ins_grow |=> count_q == $past(count_q) + 1'b1, "insert lost")
  `BMHQ_ASSERT(a_pos_range, op_busy |-> (pos_q != '0 && pos_q <= count_q), "bad heap position")

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking testbench for the binary min-heap priority queue unit.
`timescale 1ns / 1ps

module testbench;
  import bmhq_pkg::*;

  localparam int unsigned CAP     = CAPACITY_DEF;
  localparam int unsigned KEY_W   = KEY_BITS_DEF;
  localparam int unsigned ID_W    = ID_BITS_DEF;
  localparam int unsigned COUNT_W = $clog2(CAP + 1);
  localparam int unsigned S_W     = ((KEY_W + ID_W + 7) / 8) * 8;
  localparam int unsigned M_W     = ((KEY_W + ID_W + COUNT_W + 1 + 7) / 8) * 8;

  // The unused command code behaves as a peek.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS = 1200;
  localparam int HOLD_AT      = 1500;
  localparam int HOLD_LEN     = 500;
  localparam int IDLE_LIMIT   = 3000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    status_e              status;
    logic [KEY_W-1:0]     key;
    logic [ID_W-1:0]      id;
    logic [COUNT_W-1:0]   count;
    logic                 empty;
  } heap_result_t;

  typedef struct {
    logic [1:0]       op;
    logic [KEY_W-1:0] key;
    logic [ID_W-1:0]  id;
    bit               known;
    heap_result_t     want;
  } stim_row_t;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             s_axis_tvalid_i;
  logic             s_axis_tready_o;
  // in_key, in_id
  logic [S_W-1:0]   s_axis_tdata_i;
  // cmd
  logic [1:0]       s_axis_tuser_i;
  logic             m_axis_tvalid_o;
  logic             m_axis_tready_i;
  // out_key, out_id, count, empty_res
  logic [M_W-1:0]   m_axis_tdata_o;
  // status
  logic [1:0]       m_axis_tuser_o;

  binary_min_heap_queue_unit i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Shadow heap, kept 1-based like the hardware.
  logic [KEY_W-1:0] heap_key [1:CAP];
  logic [ID_W-1:0]  heap_id  [1:CAP];
  int unsigned      heap_size;

  heap_result_t heap_replies_due[$];
  stim_row_t    directed_table[$];
  stim_row_t    directed_want[$];

  int mismatch_count;
  int beats_checked;
  int n_insert, n_delete, n_peek, n_unused, n_overflow, n_underflow;
  int unsigned peak_size;
  int burst_left;

  function automatic void swap_slots(int unsigned a, int unsigned b);
    logic [KEY_W-1:0] tk;
    logic [ID_W-1:0]  td;
    tk = heap_key[a];
    td = heap_id[a];
    heap_key[a] = heap_key[b];
    heap_id[a]  = heap_id[b];
    heap_key[b] = tk;
    heap_id[b]  = td;
  endfunction

  // Applies one command to the shadow heap and returns the result it must give.
  function automatic heap_result_t heap_apply(logic [1:0] op, logic [KEY_W-1:0] k,
                                              logic [ID_W-1:0] d);
    heap_result_t r;
    int unsigned  pos;
    int unsigned  child;
    r = '0;
    r.status = STAT_OK;
    case (op)
      CMD_INSERT: begin
        if (heap_size >= CAP) begin
          r.status = STAT_OVERFLOW;
        end else begin
          heap_size++;
          heap_key[heap_size] = k;
          heap_id[heap_size]  = d;
          pos = heap_size;
          // Equal keys stay put: only a strictly larger parent moves down.
          while (pos > 1 && heap_key[pos / 2] > heap_key[pos]) begin
            swap_slots(pos, pos / 2);
            pos = pos / 2;
          end
        end
        if (heap_size > 0) begin
          r.key = heap_key[1];
          r.id  = heap_id[1];
        end
      end
      CMD_DELETE: begin
        if (heap_size == 0) begin
          r.status = STAT_UNDERFLOW;
        end else begin
          r.key = heap_key[1];
          r.id  = heap_id[1];
          swap_slots(1, heap_size);
          heap_size--;
          pos = 1;
          while (2 * pos <= heap_size) begin
            child = 2 * pos;
            if (child < heap_size && heap_key[child] > heap_key[child + 1]) child++;
            if (!(heap_key[pos] > heap_key[child])) break;
            swap_slots(pos, child);
            pos = child;
          end
        end
      end
      default: begin
        if (heap_size == 0) begin
          r.status = STAT_UNDERFLOW;
        end else begin
          r.key = heap_key[1];
          r.id  = heap_id[1];
        end
      end
    endcase
    r.count = heap_size[COUNT_W-1:0];
    r.empty = (heap_size == 0);
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [KEY_W-1:0] got, logic [KEY_W-1:0] want);
    $display("ERROR at %0t ns, result beat %0d: %s is %0h, expected %0h",
             $time, beats_checked, field, got, want);
    mismatch_count++;
  endtask

  function automatic void row_check(logic [1:0] op, logic [KEY_W-1:0] k, logic [ID_W-1:0] d);
    stim_row_t row;
    row.op    = op;
    row.key   = k;
    row.id    = d;
    row.known = 1'b0;
    row.want  = '0;
    directed_table.push_back(row);
  endfunction

  function automatic void row_known(logic [1:0] op, logic [KEY_W-1:0] k, logic [ID_W-1:0] d,
                                    status_e st, logic [KEY_W-1:0] wk, logic [ID_W-1:0] wd,
                                    logic [COUNT_W-1:0] cnt);
    stim_row_t row;
    row.op           = op;
    row.key          = k;
    row.id           = d;
    row.known        = 1'b1;
    row.want.status  = st;
    row.want.key     = wk;
    row.want.id      = wd;
    row.want.count   = cnt;
    row.want.empty   = (cnt == 0);
    directed_table.push_back(row);
  endfunction

  // Offers one beat, waits for it to be taken, then maybe pauses between bursts.
  task automatic offer_command(logic [1:0] op, logic [KEY_W-1:0] k, logic [ID_W-1:0] d);
    int gap;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= S_W'({d, k});
    s_axis_tuser_i  <= op;
    do @(posedge clk_i); while (!s_axis_tready_o);
    if (burst_left == 0) begin
      gap = $urandom_range(1, 12);
      burst_left = ($urandom_range(0, 3) == 0) ? 100 : $urandom_range(1, 30);
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end else begin
      burst_left--;
    end
  endtask

  // Monitor: checks result beats against the oldest expectation, predicts on accepted beats.
  always @(posedge clk_i) begin
    heap_result_t got;
    heap_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.status = status_e'(m_axis_tuser_o);
      got.key    = m_axis_tdata_o[KEY_W-1:0];
      got.id     = m_axis_tdata_o[KEY_W +: ID_W];
      got.count  = m_axis_tdata_o[KEY_W + ID_W +: COUNT_W];
      got.empty  = m_axis_tdata_o[KEY_W + ID_W + COUNT_W];
      if (heap_replies_due.size() == 0) begin
        report_mismatch("unexpected beat, status", got.status, 0);
      end else begin
        want = heap_replies_due.pop_front();
        if (got.status !== want.status) report_mismatch("status", got.status, want.status);
        if (got.key !== want.key) report_mismatch("out_key", got.key, want.key);
        if (got.id !== want.id) report_mismatch("out_id", got.id, want.id);
        if (got.count !== want.count) report_mismatch("count", got.count, want.count);
        if (got.empty !== want.empty) report_mismatch("empty_res", got.empty, want.empty);
      end
      beats_checked++;
    end
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o) begin
      want = heap_apply(s_axis_tuser_i, s_axis_tdata_i[KEY_W-1:0],
                        s_axis_tdata_i[KEY_W +: ID_W]);
      case (s_axis_tuser_i)
        CMD_INSERT: n_insert++;
        CMD_DELETE: n_delete++;
        CMD_PEEK:   n_peek++;
        default:    n_unused++;
      endcase
      if (want.status == STAT_OVERFLOW) n_overflow++;
      if (want.status == STAT_UNDERFLOW) n_underflow++;
      if (heap_size > peak_size) peak_size = heap_size;
      // Rows of the directed table with a typed-in result are checked against it.
      if (directed_want.size() != 0) begin
        if (directed_want[0].known) want = directed_want[0].want;
        void'(directed_want.pop_front());
      end
      heap_replies_due.push_back(want);
    end
  end

  // Receiver: changes its stall pattern now and then, and holds off once for a long stretch.
  initial begin
    int mode;
    int span;
    int cycle_no;
    bit held_off;
    cycle_no = 0;
    held_off = 1'b0;
    m_axis_tready_i <= 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 200);
      repeat (span) begin
        @(posedge clk_i);
        cycle_no++;
        if (!held_off && cycle_no >= HOLD_AT) begin
          held_off = 1'b1;
          m_axis_tready_i <= 1'b0;
          repeat (HOLD_LEN) @(posedge clk_i);
          cycle_no += HOLD_LEN;
        end
        case (mode)
          0: m_axis_tready_i <= 1'b1;
          1: m_axis_tready_i <= 1'($urandom_range(0, 1));
          2: m_axis_tready_i <= ($urandom_range(0, 3) == 0);
          default: m_axis_tready_i <= cycle_no[2];
        endcase
      end
    end
  end

  // Watchdog: ends the run when no beat moves on either side for too long.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Timeout: no beat accepted for %0d cycles", IDLE_LIMIT);
    $display("FAIL binary_min_heap_queue_unit");
    $finish;
  end

  initial begin
    int phase_kind;
    int phase_len;
    int items_sent;
    int pick;
    logic [1:0]       op;
    logic [KEY_W-1:0] k;
    rst_ni          <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    s_axis_tuser_i  <= '0;
    heap_size      = 0;
    peak_size      = 0;
    mismatch_count = 0;
    beats_checked  = 0;
    burst_left     = 0;

    // Empty heap: every read command underflows, the unused code included.
    row_known(CMD_PEEK,   '0, '0, STAT_UNDERFLOW, '0, '0, 0);
    row_known(CMD_DELETE, '0, '0, STAT_UNDERFLOW, '0, '0, 0);
    row_known(CMD_UNUSED, '0, '0, STAT_UNDERFLOW, '0, '0, 0);
    row_known(CMD_INSERT, '1, '1, STAT_OK, '1, '1, 1);
    row_known(CMD_INSERT, '0, '0, STAT_OK, '0, '0, 2);
    // Equal keys must not be exchanged, which shows up in the ids returned later.
    row_check(CMD_INSERT, 32'd5, 16'h1234);
    row_check(CMD_INSERT, 32'd5, 16'hABCD);
    row_check(CMD_INSERT, 32'd0, 16'h5555);
    row_check(CMD_INSERT, 32'h8000_0000, 16'h8000);
    row_check(CMD_INSERT, 32'h7FFF_FFFF, 16'h7FFF);
    row_check(CMD_PEEK,   32'hDEAD_BEEF, 16'hC0DE);
    row_check(CMD_UNUSED, '0, '0);
    repeat (6) row_check(CMD_DELETE, '0, '0);
    // Removing the last entry returns it and leaves the heap empty.
    row_known(CMD_DELETE, '0, '0, STAT_OK, '1, '1, 0);
    row_known(CMD_DELETE, '0, '0, STAT_UNDERFLOW, '0, '0, 0);
    row_known(CMD_INSERT, 32'd1, 16'h00FF, STAT_OK, 32'd1, 16'h00FF, 1);
    row_check(CMD_DELETE, '1, '1);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_table[i]) begin
      directed_want.push_back(directed_table[i]);
      offer_command(directed_table[i].op, directed_table[i].key, directed_table[i].id);
    end

    // Random part: fill, drain and mixed phases so the heap swings between empty and full.
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      phase_kind = $urandom_range(0, 2);
      phase_len  = (phase_kind == 2) ? $urandom_range(40, 100) : $urandom_range(90, 160);
      repeat (phase_len) begin
        pick = $urandom_range(0, 99);
        case (phase_kind)
          0: op = (pick < 85) ? CMD_INSERT : (pick < 93) ? CMD_DELETE :
                  (pick < 98) ? CMD_PEEK : CMD_UNUSED;
          1: op = (pick < 10) ? CMD_INSERT : (pick < 90) ? CMD_DELETE :
                  (pick < 97) ? CMD_PEEK : CMD_UNUSED;
          default: op = (pick < 45) ? CMD_INSERT : (pick < 80) ? CMD_DELETE :
                        (pick < 95) ? CMD_PEEK : CMD_UNUSED;
        endcase
        pick = $urandom_range(0, 9);
        if (pick < 5)      k = $urandom;
        else if (pick < 8) k = $urandom_range(0, 7);
        else if (pick < 9) k = '0;
        else               k = '1;
        offer_command(op, k, ID_W'($urandom_range(0, 65535)));
        items_sent++;
      end
    end

    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (heap_replies_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Ran %0d inserts, %0d deletes, %0d peeks and %0d unused-code commands",
             n_insert, n_delete, n_peek, n_unused);
    $display("%0d overflows, %0d underflows, peak fill %0d of %0d, %0d result beats checked",
             n_overflow, n_underflow, peak_size, CAP, beats_checked);
    if (mismatch_count == 0) begin
      $display("PASS binary_min_heap_queue_unit");
    end else begin
      $display("FAIL binary_min_heap_queue_unit");
    end
    $finish;
  end

endmodule

// ===== binary_min_heap_queue_unit.f =====
+incdir+rtl/core
rtl/core/bmhq_pkg.sv
rtl/core/binary_min_heap_queue_unit.sv
test/testbench.sv
